[design/assert_macros.svh]
// Assertion macros shared by the FFT engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked out of reset only.
`define RFFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define RFFT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/rfft_pkg.sv]
// Shared constants, twiddle ROM and arithmetic helpers of the FFT engine.
`timescale 1ns / 1ps
package rfft_pkg;

  localparam int MAX_LOG2   = 10;
  localparam int MAX_POINTS = 1 << MAX_LOG2;
  localparam int IDX_W      = MAX_LOG2;
  localparam int CNT_W      = MAX_LOG2 + 1;
  localparam int SAMPLE_W   = 16;
  localparam int STORE_W    = 28;
  localparam int WORD_W     = 2 * STORE_W;
  localparam int TW_W       = 17;
  localparam int PROD_W     = TW_W + STORE_W;
  localparam int TW_FRAC    = 15;
  localparam int T_W        = PROD_W + 1 - TW_FRAC;
  localparam int SUM_W      = T_W + 1;
  localparam int CFG_W      = 4;
  localparam int LOG_W      = 4;
  localparam int ROM_BITS   = MAX_LOG2 - 2;
  localparam int ROM_DEPTH  = 1 << ROM_BITS;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_RUN   = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic CFG_LOG2 = 1'b0;
  localparam logic CFG_INV  = 1'b1;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  localparam logic signed [STORE_W-1:0] STORE_MAX = {1'b0, {(STORE_W-1){1'b1}}};
  localparam logic signed [STORE_W-1:0] STORE_MIN = {1'b1, {(STORE_W-1){1'b0}}};

  // {cos, sin} of the first quadrant at scale 2^15
  typedef logic [31:0] tw_rom_t [ROM_DEPTH];

  function automatic logic [15:0] q30_to_q15(input logic signed [63:0] v);
    logic [63:0] u;
    u = (v < 0) ? 64'd0 : v;
    u = (u + (64'd1 << 14)) >> 15;
    return u[15:0];
  endfunction

  function automatic tw_rom_t tw_build();
    tw_rom_t rom;
    logic [63:0] th;
    logic [63:0] ct;
    logic [63:0] st;
    logic signed [63:0] cs;
    logic signed [63:0] ss;
    for (int r = 0; r < ROM_DEPTH; r++) begin
      th = ((64'(r) << (30 - ROM_BITS)) * HALF_PI_Q30) >> 30;
      ct = ONE_Q30;
      st = th;
      cs = ONE_Q30;
      ss = th;
      for (int k = 1; k <= 9; k++) begin
        ct = ((((ct * th) >> 30) * th) >> 30) / 64'((2 * k - 1) * (2 * k));
        st = ((((st * th) >> 30) * th) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) begin
          cs = cs - ct;
          ss = ss - st;
        end else begin
          cs = cs + ct;
          ss = ss + st;
        end
      end
      rom[r] = {q30_to_q15(cs), q30_to_q15(ss)};
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = tw_build();

  function automatic logic [IDX_W-1:0] bit_rev(input logic [IDX_W-1:0] x);
    logic [IDX_W-1:0] y;
    for (int b = 0; b < IDX_W; b++) begin
      y[b] = x[IDX_W-1-b];
    end
    return y;
  endfunction

  function automatic logic signed [STORE_W-1:0] sat_store(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(STORE_MAX)) return STORE_MAX;
    if (v < SUM_W'(STORE_MIN)) return STORE_MIN;
    return v[STORE_W-1:0];
  endfunction

endpackage

[design/rfft_ram.sv]
// Simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module rfft_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 56,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/radix2_fft_engine.sv]
// Top level of the in-place radix-2 FFT engine with its sample store.
//
// Input channel (in_valid/in_ready) carries one command item: kind 0 writes
// a sample at in_point_index, kind 1 runs the transform over the first
// 2^log2_points entries, kind 2 reads one bin. Result channel
// (out_valid/out_ready) returns one item for a run (transform_done set, bins
// zero) and one for a read (bin value, transform_done clear).
// A write goes into the store in the cycle it is accepted and needs no
// result slot. A read captures the bin in S_RD, then waits in S_PUT while
// the result register is still full. A run swaps each index with a higher
// bit-reversed partner (S_RV_A to S_RV_D), does each butterfly in S_BF_A
// to S_BF_F and in inverse mode scales each point in S_SC_A and S_SC_B,
// paced by the single read and single write port of the store. Configuration
// (cfg_we/cfg_index/cfg_wdata) must be written by the user only while idle;
// the block does not enforce it; index 0 is log2_points, 1 inverse_mode.
// Reset (rst_n low, synchronous) returns to idle, empties the result
// register and sets log2_points to 10, forward mode. Store contents are
// undefined until written. While the receiver stalls, the result stays
// in the output register and sample writes are still taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module radix2_fft_engine (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [1:0]                               in_kind,
  input  logic [rfft_pkg::IDX_W-1:0]               in_point_index,
  input  logic signed [rfft_pkg::SAMPLE_W-1:0]     in_sample_real,
  input  logic signed [rfft_pkg::SAMPLE_W-1:0]     in_sample_imag,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [rfft_pkg::STORE_W-1:0]      out_bin_real,
  output logic signed [rfft_pkg::STORE_W-1:0]      out_bin_imag,
  output logic                                     out_transform_done,
  input  logic                                     cfg_we,
  input  logic                                     cfg_index,
  input  logic [rfft_pkg::CFG_W-1:0]               cfg_wdata
);

  localparam int SW = rfft_pkg::STORE_W;
  localparam int IW = rfft_pkg::IDX_W;
  localparam int CW = rfft_pkg::CNT_W;
  localparam int LW = rfft_pkg::LOG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_PUT,
    S_RV_A, S_RV_B, S_RV_C, S_RV_D,
    S_BF_A, S_BF_B, S_BF_C, S_BF_D, S_BF_E, S_BF_F,
    S_SC_A, S_SC_B
  } state_t;

  state_t state_r;

  logic [LW-1:0] cfg_log2_r;
  logic          cfg_inv_r;
  logic [LW-1:0] l_r;
  logic [LW-1:0] s_r;
  logic [CW-1:0] i_r;
  logic [IW-1:0] j_r;
  logic [CW-1:0] base_r;

  logic                                    out_valid_r;
  logic signed [SW-1:0]                    out_re_r, out_im_r;
  logic                                    out_done_r;
  logic signed [SW-1:0]                    hold_re_r, hold_im_r;
  logic                                    hold_done_r;
  logic [rfft_pkg::WORD_W-1:0]             a_r;
  logic signed [rfft_pkg::TW_W-1:0]        wr_r, wi_r;
  logic signed [rfft_pkg::PROD_W-1:0]      p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic signed [rfft_pkg::T_W-1:0]         tr_r, ti_r;
  logic [rfft_pkg::WORD_W-1:0]             nv_r;

  logic                        ram_we;
  logic [IW-1:0]               ram_waddr, ram_raddr;
  logic [rfft_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

  rfft_ram #(
    .DEPTH (rfft_pkg::MAX_POINTS),
    .WIDTH (rfft_pkg::WORD_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Derived sizes and addresses
  logic [CW-1:0]        n_pts, len, half;
  logic [CW-1:0]        u_addr, v_addr, base_sum;
  logic [IW-1:0]        rev;
  logic [IW-1:0]        tw_k;
  logic [31:0]          tw_ent;
  logic signed [rfft_pkg::TW_W-1:0] tw_c, tw_s, tw_wr, tw_wi;
  logic [LW-1:0]        run_l;
  logic signed [SW-1:0] rd_re, rd_im, bf_ur, bf_ui;
  logic signed [rfft_pkg::PROD_W:0] d_re, d_im;
  logic signed [rfft_pkg::SUM_W-1:0] sum_re, sum_im, dif_re, dif_im;
  logic signed [SW:0]   sc_re, sc_im, sc_half;
  logic [SW-1:0]        sc_re_q, sc_im_q;
  logic                 take_in, slot_free;

  assign n_pts  = CW'(1) << l_r;
  assign len    = CW'(1) << s_r;
  assign half   = len >> 1;
  assign u_addr = base_r + CW'(j_r);
  assign v_addr = u_addr + half;
  assign base_sum = base_r + len;
  assign rev    = rfft_pkg::bit_rev(i_r[IW-1:0]) >> (LW'(rfft_pkg::MAX_LOG2) - l_r);

  assign tw_k   = j_r << (LW'(rfft_pkg::MAX_LOG2) - s_r);
  assign tw_ent = rfft_pkg::TW_ROM[tw_k[rfft_pkg::ROM_BITS-1:0]];
  assign tw_c   = $signed({1'b0, tw_ent[31:16]});
  assign tw_s   = $signed({1'b0, tw_ent[15:0]});

  always_comb begin
    unique case (tw_k[IW-1:IW-2])
      2'd0: begin tw_wr = tw_c;  tw_wi = tw_s;  end
      2'd1: begin tw_wr = -tw_s; tw_wi = tw_c;  end
      2'd2: begin tw_wr = -tw_c; tw_wi = -tw_s; end
      default: begin tw_wr = tw_s; tw_wi = -tw_c; end
    endcase
  end

  always_comb begin
    if (cfg_log2_r == '0) begin
      run_l = LW'(1);
    end else if (cfg_log2_r > LW'(rfft_pkg::MAX_LOG2)) begin
      run_l = LW'(rfft_pkg::MAX_LOG2);
    end else begin
      run_l = cfg_log2_r;
    end
  end

  assign rd_re = $signed(ram_rdata[2*SW-1:SW]);
  assign rd_im = $signed(ram_rdata[SW-1:0]);
  assign bf_ur = $signed(a_r[2*SW-1:SW]);
  assign bf_ui = $signed(a_r[SW-1:0]);

  // Rounded twiddle products, then butterfly sums
  assign d_re   = (p_rr_r - p_ii_r) + (rfft_pkg::PROD_W + 1)'(1 << (rfft_pkg::TW_FRAC - 1));
  assign d_im   = (p_ri_r + p_ir_r) + (rfft_pkg::PROD_W + 1)'(1 << (rfft_pkg::TW_FRAC - 1));
  assign sum_re = rfft_pkg::SUM_W'(bf_ur) + rfft_pkg::SUM_W'(tr_r);
  assign sum_im = rfft_pkg::SUM_W'(bf_ui) + rfft_pkg::SUM_W'(ti_r);
  assign dif_re = rfft_pkg::SUM_W'(bf_ur) - rfft_pkg::SUM_W'(tr_r);
  assign dif_im = rfft_pkg::SUM_W'(bf_ui) - rfft_pkg::SUM_W'(ti_r);

  // Inverse scaling: round half up, divide by the size
  assign sc_half = (SW + 1)'(1) <<< (l_r - LW'(1));
  assign sc_re   = ((SW + 1)'(rd_re) + sc_half) >>> l_r;
  assign sc_im   = ((SW + 1)'(rd_im) + sc_half) >>> l_r;
  assign sc_re_q = sc_re[SW-1:0];
  assign sc_im_q = sc_im[SW-1:0];

  assign in_ready  = (state_r == S_IDLE);
  assign take_in   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = in_point_index;
    ram_wdata = {SW'(in_sample_real), SW'(in_sample_imag)};
    ram_raddr = in_point_index;
    unique case (state_r)
      S_IDLE: ram_we = take_in && (in_kind == rfft_pkg::KIND_WRITE);
      S_RV_A: ram_raddr = i_r[IW-1:0];
      S_RV_B: ram_raddr = rev;
      S_RV_C: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[IW-1:0];
        ram_wdata = ram_rdata;
      end
      S_RV_D: begin
        ram_we    = 1'b1;
        ram_waddr = rev;
        ram_wdata = a_r;
      end
      S_BF_A: ram_raddr = u_addr[IW-1:0];
      S_BF_B: ram_raddr = v_addr[IW-1:0];
      S_BF_E: begin
        ram_we    = 1'b1;
        ram_waddr = u_addr[IW-1:0];
        ram_wdata = {rfft_pkg::sat_store(sum_re), rfft_pkg::sat_store(sum_im)};
      end
      S_BF_F: begin
        ram_we    = 1'b1;
        ram_waddr = v_addr[IW-1:0];
        ram_wdata = nv_r;
      end
      S_SC_A: ram_raddr = i_r[IW-1:0];
      S_SC_B: begin
        ram_we    = 1'b1;
        ram_waddr = i_r[IW-1:0];
        ram_wdata = {sc_re_q, sc_im_q};
      end
      default: ram_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_log2_r  <= LW'(10);
      cfg_inv_r   <= 1'b0;
      out_valid_r <= 1'b0;
      l_r         <= LW'(1);
      s_r         <= LW'(1);
      i_r         <= '0;
      j_r         <= '0;
      base_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          rfft_pkg::CFG_LOG2: cfg_log2_r <= cfg_wdata;
          rfft_pkg::CFG_INV:  cfg_inv_r  <= cfg_wdata[0];
          default: cfg_inv_r <= cfg_inv_r;
        endcase
      end
      // drop the item once taken; a new one loaded below takes its place
      if (out_valid_r && out_ready && state_r != S_PUT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (take_in && in_kind == rfft_pkg::KIND_READ) begin
            state_r <= S_RD;
          end else if (take_in && in_kind == rfft_pkg::KIND_RUN) begin
            l_r         <= run_l;
            i_r         <= '0;
            hold_re_r   <= '0;
            hold_im_r   <= '0;
            hold_done_r <= 1'b1;
            state_r     <= S_RV_A;
          end
        end
        S_RD: begin
          hold_re_r   <= rd_re;
          hold_im_r   <= rd_im;
          hold_done_r <= 1'b0;
          state_r     <= S_PUT;
        end
        S_PUT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            out_re_r    <= hold_re_r;
            out_im_r    <= hold_im_r;
            out_done_r  <= hold_done_r;
            state_r     <= S_IDLE;
          end
        end
        S_RV_A: begin
          if (CW'(rev) > i_r) begin
            state_r <= S_RV_B;
          end else if (i_r + CW'(1) == n_pts) begin
            s_r     <= LW'(1);
            j_r     <= '0;
            base_r  <= '0;
            state_r <= S_BF_A;
          end else begin
            i_r <= i_r + CW'(1);
          end
        end
        S_RV_B: begin
          a_r     <= ram_rdata;
          state_r <= S_RV_C;
        end
        S_RV_C: state_r <= S_RV_D;
        S_RV_D: begin
          // swap done: advance to the next index
          if (i_r + CW'(1) == n_pts) begin
            s_r     <= LW'(1);
            j_r     <= '0;
            base_r  <= '0;
            state_r <= S_BF_A;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_RV_A;
          end
        end
        S_BF_A: begin
          wr_r    <= tw_wr;
          wi_r    <= cfg_inv_r ? -tw_wi : tw_wi;
          state_r <= S_BF_B;
        end
        S_BF_B: begin
          a_r     <= ram_rdata;
          state_r <= S_BF_C;
        end
        S_BF_C: begin
          p_rr_r  <= wr_r * rd_re;
          p_ii_r  <= wi_r * rd_im;
          p_ri_r  <= wr_r * rd_im;
          p_ir_r  <= wi_r * rd_re;
          state_r <= S_BF_D;
        end
        S_BF_D: begin
          tr_r    <= d_re[rfft_pkg::PROD_W:rfft_pkg::TW_FRAC];
          ti_r    <= d_im[rfft_pkg::PROD_W:rfft_pkg::TW_FRAC];
          state_r <= S_BF_E;
        end
        S_BF_E: begin
          nv_r    <= {rfft_pkg::sat_store(dif_re), rfft_pkg::sat_store(dif_im)};
          state_r <= S_BF_F;
        end
        S_BF_F: begin
          state_r <= S_BF_A;
          if (base_sum < n_pts) begin
            base_r <= base_sum;
          end else begin
            base_r <= '0;
            if (CW'(j_r) + CW'(1) < half) begin
              j_r <= j_r + IW'(1);
            end else begin
              j_r <= '0;
              if (s_r == l_r) begin
                i_r     <= '0;
                state_r <= cfg_inv_r ? S_SC_A : S_PUT;
              end else begin
                s_r <= s_r + LW'(1);
              end
            end
          end
        end
        S_SC_A: state_r <= S_SC_B;
        S_SC_B: begin
          if (i_r + CW'(1) == n_pts) begin
            state_r <= S_PUT;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_SC_A;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bin_real       = out_re_r;
  assign out_bin_imag       = out_im_r;
  assign out_transform_done = out_done_r;

  `RFFT_ASSERT(a_idle_write_only_sample, (state_r == S_IDLE && ram_we) |-> (in_valid && in_kind == rfft_pkg::KIND_WRITE), "store written in idle without a sample item")
  `RFFT_ASSERT(a_bf_in_range, (state_r == S_BF_B) |-> (v_addr < n_pts && s_r >= LW'(1) && s_r <= l_r), "butterfly address beyond transform size")
  `RFFT_ASSERT(a_put_on_slot, (state_r == S_PUT && slot_free) |=> (out_valid_r && state_r == S_IDLE), "result not loaded when slot free")
  `RFFT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r, "result register not emptied by reset")

endmodule

[test/tb_top.sv]
// Self-checking testbench for the radix-2 FFT engine with a bin predictor.
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [27:0] re;
  logic signed [27:0] im;
  logic               done;
} fft_bin_t;

class fft_scoreboard;
  logic signed [27:0] re_mem [1024];
  logic signed [27:0] im_mem [1024];
  bit                 written [1024];
  logic [3:0]         log2_reg;
  bit                 inv_reg;
  fft_bin_t           bin_q [$];
  int                 errors;

  function new();
    log2_reg = 4'd10;
    inv_reg  = 1'b0;
    errors   = 0;
  endfunction

  function void set_reg(input logic idx, input logic [3:0] val);
    if (idx == rfft_pkg::CFG_LOG2) log2_reg = val;
    else inv_reg = val[0];
  endfunction

  function longint clamp28(input longint v);
    if (v > 134217727) return 134217727;
    if (v < -134217728) return -134217728;
    return v;
  endfunction

  function longint round_down(input longint v, input int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function longint q30_round(input longint v);
    if (v < 0) return 0;
    return (v + 16384) >>> 15;
  endfunction

  // exp(+2*pi*i*j/2^s) at scale 2^15 from a Q30 Taylor series
  function void twiddle(input longint j, input int s, output longint wr, output longint wi);
    longint unsigned ph, r, th, ct, st;
    longint cs, ss, c, sn;
    int quad;
    ph = (j << (32 - s)) & 64'hFFFF_FFFF;
    quad = int'(ph >> 30);
    r = ph & 64'h3FFF_FFFF;
    th = (r * 64'd1686629713) >> 30;
    ct = 64'd1 << 30;
    st = th;
    cs = longint'(64'd1 << 30);
    ss = longint'(th);
    for (int k = 1; k <= 9; k++) begin
      ct = ((((ct * th) >> 30) * th) >> 30) / longint'((2 * k - 1) * (2 * k));
      st = ((((st * th) >> 30) * th) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        cs = cs - longint'(ct);
        ss = ss - longint'(st);
      end else begin
        cs = cs + longint'(ct);
        ss = ss + longint'(st);
      end
    end
    c = q30_round(cs);
    sn = q30_round(ss);
    case (quad)
      0: begin wr = c; wi = sn; end
      1: begin wr = -sn; wi = c; end
      2: begin wr = -c; wi = -sn; end
      default: begin wr = sn; wi = -c; end
    endcase
  endfunction

  function void transform();
    int lg, n, rev;
    longint wr, wi, ur, ui, vr, vi, tr, ti;
    logic signed [27:0] t;
    lg = (log2_reg == 0) ? 1 : ((log2_reg > 10) ? 10 : int'(log2_reg));
    n = 1 << lg;
    for (int i = 0; i < n; i++) begin
      rev = 0;
      for (int b = 0; b < lg; b++) rev |= ((i >> b) & 1) << (lg - 1 - b);
      if (i < rev) begin
        t = re_mem[i]; re_mem[i] = re_mem[rev]; re_mem[rev] = t;
        t = im_mem[i]; im_mem[i] = im_mem[rev]; im_mem[rev] = t;
      end
    end
    for (int s = 1; s <= lg; s++) begin
      for (int j = 0; j < (1 << (s - 1)); j++) begin
        twiddle(j, s, wr, wi);
        if (inv_reg) wi = -wi;
        for (int b = 0; b < n; b += (1 << s)) begin
          ur = re_mem[b + j];
          ui = im_mem[b + j];
          vr = re_mem[b + j + (1 << (s - 1))];
          vi = im_mem[b + j + (1 << (s - 1))];
          tr = round_down(wr * vr - wi * vi, 15);
          ti = round_down(wr * vi + wi * vr, 15);
          re_mem[b + j] = 28'(clamp28(ur + tr));
          im_mem[b + j] = 28'(clamp28(ui + ti));
          re_mem[b + j + (1 << (s - 1))] = 28'(clamp28(ur - tr));
          im_mem[b + j + (1 << (s - 1))] = 28'(clamp28(ui - ti));
        end
      end
    end
    if (inv_reg) begin
      for (int i = 0; i < n; i++) begin
        re_mem[i] = 28'(round_down(re_mem[i], lg));
        im_mem[i] = 28'(round_down(im_mem[i], lg));
      end
    end
  endfunction

  function void note_input(input logic [1:0] kind, input logic [9:0] idx,
                           input logic signed [15:0] sr, input logic signed [15:0] si);
    case (kind)
      rfft_pkg::KIND_WRITE: begin
        re_mem[idx] = 28'(sr);
        im_mem[idx] = 28'(si);
        written[idx] = 1'b1;
      end
      rfft_pkg::KIND_RUN: begin
        transform();
        bin_q.push_back('{re: '0, im: '0, done: 1'b1});
      end
      rfft_pkg::KIND_READ: bin_q.push_back('{re: re_mem[idx], im: im_mem[idx], done: 1'b0});
      default: ;
    endcase
  endfunction

  function void check_result(input logic signed [27:0] re, input logic signed [27:0] im,
                             input logic done);
    fft_bin_t exp_bin;
    if (bin_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result re=%0d im=%0d done=%0b", re, im, done);
      return;
    end
    exp_bin = bin_q.pop_front();
    if (re !== exp_bin.re || im !== exp_bin.im || done !== exp_bin.done) begin
      errors++;
      if (errors <= 10)
        $display("bin mismatch: expected re=%0d im=%0d done=%0b, got re=%0d im=%0d done=%0b",
                 exp_bin.re, exp_bin.im, exp_bin.done, re, im, done);
    end
  endfunction
endclass

module tb_top;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int STALL_LIMIT = 200000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_kind = rfft_pkg::KIND_WRITE;
  logic [9:0]        in_point_index = '0;
  logic signed [15:0] in_sample_real = '0;
  logic signed [15:0] in_sample_imag = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [27:0] out_bin_real;
  logic signed [27:0] out_bin_imag;
  logic              out_transform_done;
  logic              cfg_we = 1'b0;
  logic              cfg_index = rfft_pkg::CFG_LOG2;
  logic [3:0]        cfg_wdata = '0;

  fft_scoreboard sb = new();
  bit quiet = 1'b0;
  int item_count = 0;
  int idle_cycles = 0;

  radix2_fft_engine i_dut (.*);

  always #2 clk = ~clk;

  always @(negedge clk) out_ready <= quiet || ($urandom_range(99) >= 9);

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_input(in_kind, in_point_index, in_sample_real, in_sample_imag);
      if (out_valid && out_ready)
        sb.check_result(out_bin_real, out_bin_imag, out_transform_done);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send(input logic [1:0] kind, input logic [9:0] idx,
                      input logic signed [15:0] sr, input logic signed [15:0] si);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_point_index <= idx;
    in_sample_real <= sr;
    in_sample_imag <= si;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    item_count++;
  endtask

  // hold off until every expected bin is back, then let the engine settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.bin_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [3:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_sample(input int pat);
    logic signed [15:0] vals [5] = '{16'sh7FFF, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001};
    if (pat == 2) return 16'sh7FFF;
    if (pat == 1) return vals[$urandom_range(4)];
    return 16'($urandom);
  endfunction

  function automatic logic [9:0] pick_bin();
    logic [9:0] idx;
    idx = 10'($urandom_range(1023));
    if (!sb.written[idx]) idx = 10'd0;
    return idx;
  endfunction

  // pat: 0 random, 1 extremes, 2 full scale, negative keeps the current store
  task automatic run_phase(input logic [3:0] lg, input bit inv, input int pat, input int runs);
    int n;
    n = 1 << ((lg == 0) ? 1 : ((lg > 10) ? 10 : int'(lg)));
    drain();
    write_reg(rfft_pkg::CFG_LOG2, lg);
    write_reg(rfft_pkg::CFG_INV, 4'(inv));
    if (pat >= 0) begin
      for (int i = 0; i < n; i++) begin
        send(rfft_pkg::KIND_WRITE, 10'(i), pick_sample(pat), pick_sample(pat));
        if ($urandom_range(7) == 0)
          send(rfft_pkg::KIND_WRITE, 10'($urandom), pick_sample(0), pick_sample(0));
        if ($urandom_range(9) == 0)
          send(KIND_NONE, 10'($urandom), 16'($urandom), 16'($urandom));
        if ($urandom_range(5) == 0)
          send(rfft_pkg::KIND_READ, pick_bin(), 16'($urandom), 16'($urandom));
      end
    end
    repeat (runs) send(rfft_pkg::KIND_RUN, 10'($urandom), 16'($urandom), 16'($urandom));
    repeat ((n < 16) ? n + 4 : 16)
      send(rfft_pkg::KIND_READ, pick_bin(), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int phase_no;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    run_phase(4'd0, 1'b0, 1, 2);
    run_phase(4'd1, 1'b1, 1, 1);
    run_phase(4'd2, 1'b0, 2, 2);
    phase_no = 0;
    while (item_count < 300) begin
      quiet = (phase_no >= 4 && phase_no < 7);
      run_phase(($urandom_range(9) < 7) ? 4'($urandom_range(1, 4)) : 4'($urandom_range(5, 8)),
                1'($urandom_range(1)), $urandom_range(1), $urandom_range(1, 2));
      phase_no++;
    end
    // full scale run three times over 128 points drives the bins into saturation
    quiet = 1'b1;
    run_phase(4'd7, 1'b0, 2, 3);
    quiet = 1'b0;
    run_phase(4'd7, 1'b1, -1, 1);
    drain();
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
